// File: rtl/cvxh_pkg.sv
// Shared constants for the convex hull gift-wrap block.
package cvxh_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_BITS_DEF = 16;
   localparam int SMALL_SET      = 4;

endpackage

// File: rtl/cvxh_ifs.sv
// Valid/ready channel interfaces for point input and hull output.
interface cvxh_req_if #(
   parameter int COORD_BITS = cvxh_pkg::COORD_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         set_end;

   modport source (output valid, point_x, point_y, set_end, input ready);
   modport sink (input valid, point_x, point_y, set_end, output ready);
endinterface

interface cvxh_rsp_if #(
   parameter int COORD_BITS = cvxh_pkg::COORD_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] hull_x;
   logic signed [COORD_BITS-1:0] hull_y;
   logic                         hull_end;
   logic                         capacity_overflow;

   modport source (output valid, hull_x, hull_y, hull_end, capacity_overflow, input ready);
   modport sink (input valid, hull_x, hull_y, hull_end, capacity_overflow, output ready);
endinterface

// File: rtl/cvxh_ram.sv
// Generic single-port-write, registered-read RAM.
module cvxh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/convex_hull_gift_wrap_top.sv
// Gift-wrap convex hull engine: point store, wrap sequencer and hull output register.
//
// Points are taken one per cycle into a single point RAM until a transfer with set_end; the
// block then stops taking points until the last result of the set has been loaded into the
// output register. For n stored points the work is a leftmost-point search over all n, then
// for each hull point a swap into place, an orientation test against every remaining point and
// a closing test; every orientation test reads the RAM, forms differences, multiplies and
// compares in turn. Each result is read from the RAM before it is loaded into the output
// register. Sets of fewer than four points skip the wrap and are returned in input order.
// Points beyond MAX_POINTS are dropped and every result of that set carries capacity_overflow.
module convex_hull_gift_wrap_top #(
   parameter int MAX_POINTS = cvxh_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = cvxh_pkg::COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cvxh_req_if.sink   req_chan,
   cvxh_rsp_if.source rsp_chan
);

   import cvxh_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam logic [CNT_W-1:0] MAX_N   = CNT_W'(MAX_POINTS);
   localparam logic [CNT_W-1:0] SMALL_N = CNT_W'(SMALL_SET);
   localparam logic [CNT_W-1:0] ONE_N   = CNT_W'(1);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_LEFT_RD,
      ST_LEFT_CMP,
      ST_SWAP_RD,
      ST_SWAP_WR1,
      ST_SWAP_WR2,
      ST_SCAN_RD,
      ST_SCAN_DIFF,
      ST_SCAN_MUL,
      ST_SCAN_CMP,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   state_type                state_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     overflow_ff;
   logic [CNT_W-1:0]         n_ff;
   logic [CNT_W-1:0]         idx_ff;
   logic [CNT_W-1:0]         placed_ff;
   logic [IDX_W-1:0]         cur_ff;
   logic                     close_ff;
   logic signed [CB-1:0]     hx_ff;
   logic signed [CB-1:0]     hy_ff;
   logic signed [CB-1:0]     cx_ff;
   logic signed [CB-1:0]     cy_ff;
   logic signed [CB-1:0]     px_ff;
   logic signed [CB-1:0]     py_ff;
   logic signed [CB:0]       dpx_ff;
   logic signed [CB:0]       dpy_ff;
   logic signed [CB:0]       dbx_ff;
   logic signed [CB:0]       dby_ff;
   logic signed [2*CB+1:0]   m1_ff;
   logic signed [2*CB+1:0]   m2_ff;
   logic                     out_valid_ff;
   logic signed [CB-1:0]     out_x_ff;
   logic signed [CB-1:0]     out_y_ff;
   logic                     out_end_ff;
   logic                     out_ovf_ff;

   logic                     req_xfer;
   logic                     has_room;
   logic [CNT_W-1:0]         n_new;
   logic [CNT_W-1:0]         idx_next;
   logic [CNT_W-1:0]         placed_next;
   logic                     out_free;
   logic                     turn_neg;

   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   logic [2*CB-1:0]          ram_wr_data;
   logic [IDX_W-1:0]         ram_rd_addr;
   logic [2*CB-1:0]          ram_rd_data;
   logic signed [CB-1:0]     rd_x;
   logic signed [CB-1:0]     rd_y;

   cvxh_ram #(
      .WIDTH (2*CB),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_x        = ram_rd_data[2*CB-1:CB];
   assign rd_y        = ram_rd_data[CB-1:0];
   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_xfer    = req_chan.valid && (state_ff == ST_LOAD);
   assign has_room    = (count_ff < MAX_N);
   assign n_new       = has_room ? count_ff + ONE_N : count_ff;
   assign idx_next    = idx_ff + ONE_N;
   assign placed_next = placed_ff + ONE_N;
   assign out_free    = !out_valid_ff || rsp_chan.ready;
   assign turn_neg    = (m1_ff < m2_ff);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[IDX_W-1:0];
      ram_wr_data = {req_chan.point_x, req_chan.point_y};
      case (state_ff)
         ST_LOAD: begin
            ram_wr_en = req_xfer && has_room;
         end
         ST_SWAP_WR1: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_ff;
            ram_wr_data = ram_rd_data;
         end
         ST_SWAP_WR2: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = placed_ff[IDX_W-1:0];
            ram_wr_data = {hx_ff, hy_ff};
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (state_ff == ST_SWAP_RD) begin
         ram_rd_addr = placed_ff[IDX_W-1:0];
      end else if (close_ff) begin
         ram_rd_addr = '0;
      end else begin
         ram_rd_addr = idx_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         close_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_EMIT_LD && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_LOAD: begin
               if (req_xfer) begin
                  if (has_room) begin
                     count_ff <= count_ff + ONE_N;
                  end else begin
                     overflow_ff <= 1'b1;
                  end
                  if (req_chan.set_end) begin
                     n_ff   <= n_new;
                     idx_ff <= '0;
                     state_ff <= (n_new < SMALL_N) ? ST_EMIT_RD : ST_LEFT_RD;
                  end
               end
            end
            ST_LEFT_RD: begin
               state_ff <= ST_LEFT_CMP;
            end
            ST_LEFT_CMP: begin
               if (idx_ff == '0 || rd_x < hx_ff) begin
                  hx_ff  <= rd_x;
                  hy_ff  <= rd_y;
                  cur_ff <= idx_ff[IDX_W-1:0];
               end
               if (idx_next == n_ff) begin
                  placed_ff <= '0;
                  state_ff  <= ST_SWAP_RD;
               end else begin
                  idx_ff   <= idx_next;
                  state_ff <= ST_LEFT_RD;
               end
            end
            ST_SWAP_RD: begin
               state_ff <= ST_SWAP_WR1;
            end
            ST_SWAP_WR1: begin
               state_ff <= ST_SWAP_WR2;
            end
            ST_SWAP_WR2: begin
               placed_ff <= placed_next;
               if (placed_next == n_ff) begin
                  idx_ff   <= '0;
                  state_ff <= ST_EMIT_RD;
               end else begin
                  idx_ff   <= placed_next;
                  state_ff <= ST_SCAN_RD;
               end
            end
            ST_SCAN_RD: begin
               state_ff <= ST_SCAN_DIFF;
            end
            ST_SCAN_DIFF: begin
               px_ff    <= rd_x;
               py_ff    <= rd_y;
               dpx_ff   <= {rd_x[CB-1], rd_x} - {hx_ff[CB-1], hx_ff};
               dpy_ff   <= {rd_y[CB-1], rd_y} - {hy_ff[CB-1], hy_ff};
               dbx_ff   <= {cx_ff[CB-1], cx_ff} - {hx_ff[CB-1], hx_ff};
               dby_ff   <= {cy_ff[CB-1], cy_ff} - {hy_ff[CB-1], hy_ff};
               state_ff <= ST_SCAN_MUL;
            end
            ST_SCAN_MUL: begin
               m1_ff    <= dpx_ff * dby_ff;
               m2_ff    <= dbx_ff * dpy_ff;
               state_ff <= ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
               if (close_ff) begin
                  close_ff <= 1'b0;
                  if (turn_neg) begin
                     n_ff     <= placed_ff;
                     idx_ff   <= '0;
                     state_ff <= ST_EMIT_RD;
                  end else begin
                     hx_ff    <= cx_ff;
                     hy_ff    <= cy_ff;
                     state_ff <= ST_SWAP_RD;
                  end
               end else begin
                  if (idx_ff == placed_ff || turn_neg) begin
                     cx_ff  <= px_ff;
                     cy_ff  <= py_ff;
                     cur_ff <= idx_ff[IDX_W-1:0];
                  end
                  if (idx_next == n_ff) begin
                     close_ff <= 1'b1;
                  end else begin
                     idx_ff <= idx_next;
                  end
                  state_ff <= ST_SCAN_RD;
               end
            end
            ST_EMIT_RD: begin
               state_ff <= ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
               if (out_free) begin
                  out_x_ff     <= rd_x;
                  out_y_ff     <= rd_y;
                  out_end_ff   <= (idx_next == n_ff);
                  out_ovf_ff   <= overflow_ff;
                  if (idx_next == n_ff) begin
                     count_ff    <= '0;
                     overflow_ff <= 1'b0;
                     state_ff    <= ST_LOAD;
                  end else begin
                     idx_ff   <= idx_next;
                     state_ff <= ST_EMIT_RD;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.hull_x            = out_x_ff;
   assign rsp_chan.hull_y            = out_y_ff;
   assign rsp_chan.hull_end          = out_end_ff;
   assign rsp_chan.capacity_overflow = out_ovf_ff;

endmodule

// File: rtl/cvxh_checker.sv
// Port-level checker for the convex hull block, bound to the top level.
module cvxh_checker #(
   parameter int COORD_BITS = cvxh_pkg::COORD_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_set_end,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] rsp_hull_x,
   input logic signed [COORD_BITS-1:0] rsp_hull_y,
   input logic                         rsp_hull_end
);

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped without a transfer");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hull_x) && $stable(rsp_hull_y)
         && $stable(rsp_hull_end))
      else $error("rsp payload changed while stalled");

   // No new points are taken while a set is still being sent out.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hull_end |-> !req_ready)
      else $error("point accepted in the middle of a hull");

   // The last point of a set closes the input until its hull is done.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_set_end |=> !req_ready)
      else $error("input still open after the last point of a set");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid high after reset");

endmodule

bind convex_hull_gift_wrap_top cvxh_checker #(
   .COORD_BITS (COORD_BITS)
) u_cvxh_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_set_end  (req_chan.set_end),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_hull_x   (rsp_chan.hull_x),
   .rsp_hull_y   (rsp_chan.hull_y),
   .rsp_hull_end (rsp_chan.hull_end)
);
